[rtl/core/gbs_pkg.sv]
// Shared types and constants for the gaussian background subtractor.
// Depends on nothing; every module of the block but gbs_checker imports it.
package gbs_pkg;

  localparam int unsigned PIX_W     = 8;
  localparam int unsigned IDX_W     = 18;
  localparam int unsigned ADDR_W    = 18;   // store depth 2**18
  localparam int unsigned N_W       = 9;
  localparam int unsigned WGT_W     = 16;
  localparam int unsigned SUM_W     = 16;
  localparam int unsigned SQ_W      = 24;
  localparam int unsigned THR_W     = 24;
  localparam int unsigned DEV_W     = 25;
  localparam int unsigned DIV_NUM_W = 41;   // weight times deviation total
  localparam int unsigned DIV_DEN_W = 17;   // train count times 256
  localparam int unsigned QDEPTH    = 4;
  localparam int unsigned QAW       = 2;

  localparam logic [N_W-1:0]   TRAIN_RST  = 9'd200;
  localparam logic [N_W-1:0]   N_MAX      = 9'd256;
  localparam logic [WGT_W-1:0] WEIGHT_RST = 16'd512;

  typedef enum logic {
    REG_TRAIN_FRAMES = 1'b0,
    REG_WEIGHT       = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    CLS_FIRST = 2'd0,   // first training frame: write sums
    CLS_ACC   = 2'd1,   // later training frame: add to sums
    CLS_FIN   = 2'd2,   // finalize mean and threshold
    CLS_DET   = 2'd3    // classify against the model
  } cls_e;

  typedef struct packed {
    logic [PIX_W-1:0] pixel;
    logic [IDX_W-1:0] index;
    cls_e             cls;
    logic [N_W-1:0]   n;
  } item_t;

  typedef struct packed {
    logic  valid;
    item_t item;
  } q_head_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [SUM_W-1:0]  sum;
    logic [SQ_W-1:0]   sq;
    logic [N_W-1:0]    n;
    logic [PIX_W-1:0]  mean;
  } fin_ctx_t;

endpackage

[rtl/core/gbs_front.sv]
// Front end: configuration registers, frame counting, item classification
// and the short queue towards the back end. Depends on gbs_pkg.
module gbs_front (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gbs_pkg::PIX_W-1:0]   pixel_i,
  input  logic [gbs_pkg::IDX_W-1:0]   pixel_index_i,
  input  logic                        end_of_frame_i,
  output gbs_pkg::q_head_t            head_o,
  input  logic                        pop_i,
  output logic [gbs_pkg::WGT_W-1:0]   weight_o
);
  import gbs_pkg::*;

  logic [N_W-1:0]   train_q;
  logic [WGT_W-1:0] weight_q;
  logic [N_W-1:0]   fcnt_q, fcnt_d;
  logic [N_W-1:0]   n_eff;
  cls_e             cls;
  logic             push;
  item_t            qmem_q [QDEPTH];
  logic [QAW-1:0]   wptr_q, rptr_q;
  logic [QAW:0]     cnt_q;

  always_comb begin
    if (train_q == '0) begin
      n_eff = N_W'(1);
    end else if (train_q > N_MAX) begin
      n_eff = N_MAX;
    end else begin
      n_eff = train_q;
    end
    if (fcnt_q < n_eff) begin
      cls = (fcnt_q == '0) ? CLS_FIRST : CLS_ACC;
    end else if (fcnt_q == n_eff) begin
      cls = CLS_FIN;
    end else begin
      cls = CLS_DET;
    end
    fcnt_d = fcnt_q;
    if (end_of_frame_i && fcnt_q <= n_eff) begin
      fcnt_d = fcnt_q + N_W'(1);
    end
  end

  assign in_stall_o = (cnt_q == (QAW+1)'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign weight_o   = weight_q;

  assign head_o.valid = (cnt_q != '0);
  assign head_o.item  = qmem_q[rptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      train_q  <= TRAIN_RST;
      weight_q <= WEIGHT_RST;
      fcnt_q   <= '0;
      wptr_q   <= '0;
      rptr_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        case (reg_idx_e'(cfg_idx_i))
          REG_TRAIN_FRAMES: train_q  <= cfg_wdata_i[N_W-1:0];
          REG_WEIGHT:       weight_q <= cfg_wdata_i;
          default:          train_q  <= train_q;
        endcase
      end
      if (push) begin
        fcnt_q <= fcnt_d;
        wptr_q <= wptr_q + QAW'(1);
      end
      if (pop_i) begin
        rptr_q <= rptr_q + QAW'(1);
      end
      if (push && !pop_i) begin
        cnt_q <= cnt_q + (QAW+1)'(1);
      end else if (!push && pop_i) begin
        cnt_q <= cnt_q - (QAW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      qmem_q[wptr_q] <= '{pixel: pixel_i, index: pixel_index_i, cls: cls, n: n_eff};
    end
  end

endmodule

[rtl/core/gbs_div.sv]
// Pipelined restoring divider, one quotient bit per stage, with a side
// context carried along. Depends on gbs_pkg.
module gbs_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          en_i,
  input  logic                          valid_i,
  input  logic [gbs_pkg::DIV_NUM_W-1:0] num_i,
  input  logic [gbs_pkg::DIV_DEN_W-1:0] den_i,
  input  gbs_pkg::fin_ctx_t             ctx_i,
  output logic                          valid_o,
  output logic [gbs_pkg::DIV_NUM_W-1:0] quot_o,
  output gbs_pkg::fin_ctx_t             ctx_o,
  output logic                          busy_o
);
  import gbs_pkg::*;

  logic [DIV_NUM_W-1:0] v_q;
  logic [DIV_DEN_W-1:0] rem_q [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] rem_d [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] quo_q [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] quo_d [DIV_NUM_W];
  logic [DIV_NUM_W-1:0] num_q [DIV_NUM_W];
  logic [DIV_DEN_W-1:0] den_q [DIV_NUM_W];
  fin_ctx_t             ctx_q [DIV_NUM_W];

  always_comb begin
    logic [DIV_DEN_W-1:0] prem;
    logic [DIV_NUM_W-1:0] pquo;
    logic [DIV_NUM_W-1:0] pnum;
    logic [DIV_DEN_W-1:0] pden;
    logic [DIV_DEN_W:0]   trial;
    for (int k = 0; k < DIV_NUM_W; k++) begin
      if (k == 0) begin
        prem = '0;
        pquo = '0;
        pnum = num_i;
        pden = den_i;
      end else begin
        prem = rem_q[k-1];
        pquo = quo_q[k-1];
        pnum = num_q[k-1];
        pden = den_q[k-1];
      end
      trial = {prem, pnum[DIV_NUM_W-1-k]};
      if (trial >= {1'b0, pden}) begin
        rem_d[k] = DIV_DEN_W'(trial - {1'b0, pden});
        quo_d[k] = {pquo[DIV_NUM_W-2:0], 1'b1};
      end else begin
        rem_d[k] = trial[DIV_DEN_W-1:0];
        quo_d[k] = {pquo[DIV_NUM_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en_i) begin
      v_q <= {v_q[DIV_NUM_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < DIV_NUM_W; k++) begin
        rem_q[k] <= rem_d[k];
        quo_q[k] <= quo_d[k];
        num_q[k] <= (k == 0) ? num_i : num_q[k-1];
        den_q[k] <= (k == 0) ? den_i : den_q[k-1];
        ctx_q[k] <= (k == 0) ? ctx_i : ctx_q[k-1];
      end
    end
  end

  assign valid_o = v_q[DIV_NUM_W-1];
  assign quot_o  = quo_q[DIV_NUM_W-1];
  assign ctx_o   = ctx_q[DIV_NUM_W-1];
  assign busy_o  = |v_q;

endmodule

[rtl/core/gbs_fin.sv]
// Finalize pipeline: mean by division, deviation total by staged
// multiplies, threshold by a second division. Depends on gbs_pkg, gbs_div.
module gbs_fin (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        en_i,
  input  logic                        valid_i,
  input  gbs_pkg::fin_ctx_t           ctx_i,
  input  logic [gbs_pkg::WGT_W-1:0]   weight_i,
  output logic                        valid_o,
  output logic [gbs_pkg::ADDR_W-1:0]  addr_o,
  output logic [gbs_pkg::PIX_W-1:0]   mean_o,
  output logic [gbs_pkg::THR_W-1:0]   thr_o,
  output logic                        busy_o
);
  import gbs_pkg::*;

  logic                 d1_v, d2_v, d1_busy, d2_busy;
  logic [DIV_NUM_W-1:0] d1_quot, d2_quot;
  fin_ctx_t             d1_ctx, d2_ctx, m_ctx;
  logic                 x1_v_q, x2_v_q, x3_v_q, x4_v_q;
  fin_ctx_t             x1_ctx_q, x2_ctx_q, x3_ctx_q, x4_ctx_q;
  logic [23:0]          p1_q;
  logic [15:0]          mm_q;
  logic signed [26:0]   a_q;
  logic [24:0]          p2_q;
  logic [DEV_W-1:0]     dev_q;
  logic [DIV_NUM_W-1:0] prod_q;
  logic signed [26:0]   tot;

  gbs_div u_div_mean (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (valid_i),
    .num_i   ({(DIV_NUM_W-SUM_W-8)'(0), ctx_i.sum, 8'd0}),
    .den_i   ({ctx_i.n, 8'd0}),
    .ctx_i   (ctx_i),
    .valid_o (d1_v),
    .quot_o  (d1_quot),
    .ctx_o   (d1_ctx),
    .busy_o  (d1_busy)
  );

  always_comb begin
    m_ctx      = d1_ctx;
    m_ctx.mean = (d1_quot > DIV_NUM_W'(255)) ? 8'd255 : d1_quot[PIX_W-1:0];
    tot        = a_q + $signed({2'b00, p2_q});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      x1_v_q <= 1'b0;
      x2_v_q <= 1'b0;
      x3_v_q <= 1'b0;
      x4_v_q <= 1'b0;
    end else if (en_i) begin
      x1_v_q <= d1_v;
      x2_v_q <= x1_v_q;
      x3_v_q <= x2_v_q;
      x4_v_q <= x3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x1_ctx_q <= m_ctx;
      p1_q     <= m_ctx.mean * m_ctx.sum;
      mm_q     <= m_ctx.mean * m_ctx.mean;
      x2_ctx_q <= x1_ctx_q;
      a_q      <= $signed({3'b000, x1_ctx_q.sq}) - $signed({2'b00, p1_q, 1'b0});
      p2_q     <= x1_ctx_q.n * mm_q;
      x3_ctx_q <= x2_ctx_q;
      dev_q    <= tot[26] ? '0 : tot[DEV_W-1:0];
      x4_ctx_q <= x3_ctx_q;
      prod_q   <= weight_i * dev_q;
    end
  end

  gbs_div u_div_thr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en_i),
    .valid_i (x4_v_q),
    .num_i   (prod_q),
    .den_i   ({x4_ctx_q.n, 8'd0}),
    .ctx_i   (x4_ctx_q),
    .valid_o (d2_v),
    .quot_o  (d2_quot),
    .ctx_o   (d2_ctx),
    .busy_o  (d2_busy)
  );

  assign valid_o = d2_v;
  assign addr_o  = d2_ctx.addr;
  assign mean_o  = d2_ctx.mean;
  assign thr_o   = (d2_quot > DIV_NUM_W'(24'hFFFFFF)) ? 24'hFFFFFF : d2_quot[THR_W-1:0];
  assign busy_o  = d1_busy || d2_busy || x1_v_q || x2_v_q || x3_v_q || x4_v_q;

endmodule

[rtl/core/gbs_back.sv]
// Back end: per-pixel stores, accumulate and classify stage, finalize
// pipeline and output register. Depends on gbs_pkg and gbs_fin.
module gbs_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  gbs_pkg::q_head_t            head_i,
  output logic                        pop_o,
  input  logic [gbs_pkg::WGT_W-1:0]   weight_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        foreground_o,
  output logic [gbs_pkg::IDX_W-1:0]   out_index_o
);
  import gbs_pkg::*;

  logic [SUM_W-1:0] sum_mem  [2**ADDR_W];
  logic [SQ_W-1:0]  sq_mem   [2**ADDR_W];
  logic [PIX_W-1:0] mean_mem [2**ADDR_W];
  logic [THR_W-1:0] thr_mem  [2**ADDR_W];

  logic             adv, fin_busy, fin_v;
  logic             s1_v_q;
  item_t            s1_q;
  logic [SUM_W-1:0] sum_rd_q, sum_cur, sum_new;
  logic [SQ_W-1:0]  sq_rd_q, sq_cur, sq_new;
  logic [PIX_W-1:0] mean_rd_q, mean_f, diff;
  logic [THR_W-1:0] thr_rd_q, thr_f;
  logic [ADDR_W-1:0] fin_addr;
  logic             wr_acc;
  logic             fw_v_q;
  logic [ADDR_W-1:0] fw_addr_q;
  logic [SUM_W-1:0] fw_sum_q;
  logic [SQ_W-1:0]  fw_sq_q;
  logic [15:0]      psq;
  fin_ctx_t         fctx;

  assign adv   = !out_valid_o || !out_stall_i;
  assign pop_o = head_i.valid && adv &&
                 !(head_i.item.cls == CLS_DET && (fin_busy || (s1_v_q && s1_q.cls == CLS_FIN)));

  always_comb begin
    sum_cur = sum_rd_q;
    sq_cur  = sq_rd_q;
    if (fw_v_q && fw_addr_q == s1_q.index) begin
      sum_cur = fw_sum_q;
      sq_cur  = fw_sq_q;
    end
    psq    = s1_q.pixel * s1_q.pixel;
    wr_acc = 1'b0;
    case (s1_q.cls)
      CLS_FIRST: begin
        wr_acc  = s1_v_q;
        sum_new = {8'd0, s1_q.pixel};
        sq_new  = {8'd0, psq};
      end
      CLS_ACC: begin
        wr_acc  = s1_v_q;
        sum_new = sum_cur + {8'd0, s1_q.pixel};
        sq_new  = sq_cur + {8'd0, psq};
      end
      default: begin
        sum_new = sum_cur;
        sq_new  = sq_cur;
      end
    endcase
    diff = (s1_q.pixel > mean_rd_q) ? s1_q.pixel - mean_rd_q : mean_rd_q - s1_q.pixel;
    fctx = '{addr: s1_q.index, sum: sum_cur, sq: sq_cur, n: s1_q.n, mean: '0};
  end

  always_ff @(posedge clk_i) begin
    if (adv && pop_o) begin
      sum_rd_q  <= sum_mem[head_i.item.index];
      sq_rd_q   <= sq_mem[head_i.item.index];
      mean_rd_q <= mean_mem[head_i.item.index];
      thr_rd_q  <= thr_mem[head_i.item.index];
      s1_q      <= head_i.item;
    end
    if (adv && wr_acc) begin
      sum_mem[s1_q.index] <= sum_new;
      sq_mem[s1_q.index]  <= sq_new;
    end
    if (adv) begin
      fw_addr_q <= s1_q.index;
      fw_sum_q  <= sum_new;
      fw_sq_q   <= sq_new;
    end
    if (adv && fin_v) begin
      mean_mem[fin_addr] <= mean_f;
      thr_mem[fin_addr]  <= thr_f;
    end
    if (adv && s1_v_q && s1_q.cls == CLS_DET) begin
      foreground_o <= {16'd0, diff} > thr_rd_q;
      out_index_o  <= s1_q.index;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q      <= 1'b0;
      fw_v_q      <= 1'b0;
      out_valid_o <= 1'b0;
    end else if (adv) begin
      s1_v_q      <= pop_o;
      fw_v_q      <= wr_acc;
      out_valid_o <= s1_v_q && s1_q.cls == CLS_DET;
    end
  end

  gbs_fin u_fin (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (adv),
    .valid_i  (s1_v_q && s1_q.cls == CLS_FIN),
    .ctx_i    (fctx),
    .weight_i (weight_i),
    .valid_o  (fin_v),
    .addr_o   (fin_addr),
    .mean_o   (mean_f),
    .thr_o    (thr_f),
    .busy_o   (fin_busy)
  );

endmodule

[rtl/core/gaussian_background_subtractor.sv]
// Single-gaussian background subtractor, top level: front end, queue and
// back end wired together. Depends on gbs_pkg, gbs_front and gbs_back.
//
// Feed grey pixels with their raster index, marking the last pixel of each
// frame with end_of_frame. The first train_frames frames build a per-pixel
// sum and sum of squares; the frame after that turns them into a mean and a
// threshold (weight_q, Q8.8, times the variance) and gives no beats; every
// later frame gives one beat per pixel, foreground set when the pixel
// differs from the mean by more than the threshold. Sustained rate is one
// pixel per clock: the store read and update stage takes one pixel a cycle
// and a four-entry queue absorbs short output stalls. When idle, an input
// beat goes through the queue, the store read stage and the output
// register before it is offered. The only pause comes once, at the first
// classified frame: its pixels are held until the finalize pipeline (two
// 41-stage dividers and four multiply stages) has written its last mean and
// threshold. Write configuration only while idle.
module gaussian_background_subtractor (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic                        cfg_idx_i,
  input  logic [15:0]                 cfg_wdata_i,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [gbs_pkg::PIX_W-1:0]   pixel_i,
  input  logic [gbs_pkg::IDX_W-1:0]   pixel_index_i,
  input  logic                        end_of_frame_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic                        foreground_o,
  output logic [gbs_pkg::IDX_W-1:0]   out_index_o
);
  import gbs_pkg::*;

  q_head_t          head;
  logic             pop;
  logic [WGT_W-1:0] weight;

  // Classify each beat on arrival and hold it in the queue.
  gbs_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .pixel_i        (pixel_i),
    .pixel_index_i  (pixel_index_i),
    .end_of_frame_i (end_of_frame_i),
    .head_o         (head),
    .pop_i          (pop),
    .weight_o       (weight)
  );

  // Update the stores, finalize the model and emit the mask beats.
  gbs_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (head),
    .pop_o        (pop),
    .weight_i     (weight),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .foreground_o (foreground_o),
    .out_index_o  (out_index_o)
  );

endmodule

[rtl/core/gbs_checker.sv]
// Port-level checks for the background subtractor, bound to the top level.
// Depends on gaussian_background_subtractor ports only.
module gbs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic        foreground_o,
  input logic [17:0] out_index_o
);

  // A stalled output beat holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_index_o) && $stable(foreground_o))
    else $error("output beat changed under stall");

  // The queue only fills after a beat was taken.
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(in_stall_o) |-> $past(in_valid_i))
    else $error("input stall raised without an accepted beat");

  // No output beat straight out of reset.
  a_reset_quiet: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("output beat present at reset release");

endmodule

bind gaussian_background_subtractor gbs_checker u_gbs_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_stall_o   (in_stall_o),
  .out_valid_o  (out_valid_o),
  .out_stall_i  (out_stall_i),
  .foreground_o (foreground_o),
  .out_index_o  (out_index_o)
);
